### rtl/core/efr_pkg.sv
// ----------------------------------------------------------------------------
// efr_pkg
// Shared types and constants for the eight-lane serial ADC frame reader.
// ----------------------------------------------------------------------------
package efr_pkg;

	localparam int PacketBitsDef = 24;
	localparam int LanesDef      = 8;

	// packet layout: data above the flag, flag above the channel id
	localparam int IdBits  = 3;
	localparam int FlagPos = 3;
	localparam int DataLsb = 4;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_CLOCK = 1'b1;

	typedef enum logic [1:0] {
		KIND_START_OK   = 2'd0,
		KIND_START_BUSY = 2'd1,
		KIND_WORD       = 2'd2
	} kind_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} lane_ctl_t;

	typedef struct packed {
		logic       start_rsp;
		logic       busy;
		logic       frame_done;
		logic       skip_en;
		logic [7:0] skip_lane;
	} emit_req_t;

endpackage

### rtl/core/efr_if.sv
// ----------------------------------------------------------------------------
// efr_in_if / efr_out_if
// Valid/ready channels: sample requests in, result requests out.
// ----------------------------------------------------------------------------
interface efr_in_if #(
	parameter int LANES = efr_pkg::LanesDef
);
	logic             valid;
	logic             ready;
	logic             command;
	logic [LANES-1:0] sdo_bits;

	modport source (output valid, command, sdo_bits, input ready);
	modport sink   (input valid, command, sdo_bits, output ready);
endinterface

interface efr_out_if #(
	parameter int LANES       = efr_pkg::LanesDef,
	parameter int PACKET_BITS = efr_pkg::PacketBitsDef
);
	logic                                  valid;
	logic                                  ready;
	logic [1:0]                            kind;
	logic [$clog2(LANES)-1:0]              lane;
	logic [efr_pkg::IdBits-1:0]            chan_num;
	logic [PACKET_BITS-efr_pkg::DataLsb-1:0] conversion_data;
	logic                                  over_under_range;
	logic                                  last;

	modport source (output valid, kind, lane, chan_num, conversion_data,
		over_under_range, last, input ready);
	modport sink   (input valid, kind, lane, chan_num, conversion_data,
		over_under_range, last, output ready);
endinterface

### rtl/core/efr_lane.sv
// ----------------------------------------------------------------------------
// efr_lane
// One serial lane: MSB-first shift register, cleared on frame start.
// ----------------------------------------------------------------------------
module efr_lane
	import efr_pkg::*;
#(
	parameter int PACKET_BITS = PacketBitsDef
) (
	input  logic                   clk,
	input  lane_ctl_t              ctl,
	input  logic                   sdo,
	output logic [PACKET_BITS-1:0] word
);

	logic [PACKET_BITS-1:0] shift_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			if (ctl.clear) begin
				shift_q <= {{(PACKET_BITS-1){1'b0}}, sdo};
			end else begin
				shift_q <= {shift_q[PACKET_BITS-2:0], sdo};
			end
		end
	end

	assign word = shift_q;

endmodule

### rtl/core/efr_ctrl.sv
// ----------------------------------------------------------------------------
// efr_ctrl
// Frame sequencer: start/clock decode, bit counter, status lane rotation.
// ----------------------------------------------------------------------------
module efr_ctrl
	import efr_pkg::*;
#(
	parameter int PACKET_BITS = PacketBitsDef,
	parameter int LANES       = LanesDef
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  logic      command,
	output lane_ctl_t lane_ctl,
	output emit_req_t req
);

	localparam int CountW = $clog2(PACKET_BITS + 1);
	localparam int LaneW  = $clog2(LANES);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	state_t            state_q;
	logic [CountW-1:0] count_q;
	logic [LaneW-1:0]  status_q;
	logic              absent_q;

	logic is_start;
	logic is_clock;
	logic done;

	assign is_start = accept && (command == CMD_START);
	assign is_clock = accept && (command == CMD_CLOCK) && (state_q == ST_READ);
	assign done     = is_clock && (count_q == CountW'(PACKET_BITS - 1));

	always_comb begin
		lane_ctl.shift = is_clock || (is_start && (state_q == ST_IDLE));
		lane_ctl.clear = is_start;

		req.start_rsp  = is_start;
		req.busy       = (state_q == ST_READ);
		req.frame_done = done;
		req.skip_en    = !absent_q;
		req.skip_lane  = 8'(status_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			status_q <= '0;
			absent_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (is_start) begin
						state_q <= ST_READ;
						count_q <= CountW'(1);
					end
				end
				ST_READ: begin
					if (is_clock) begin
						count_q <= count_q + CountW'(1);
					end
					if (done) begin
						state_q <= ST_IDLE;
						if (absent_q || (status_q == '0)) begin
							absent_q <= 1'b0;
							status_q <= LaneW'(LANES - 1);
						end else begin
							status_q <= status_q - LaneW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/core/efr_merge.sv
// ----------------------------------------------------------------------------
// efr_merge
// Result stage: start responses and the per-lane word walk into one
// output register.
// ----------------------------------------------------------------------------
module efr_merge
	import efr_pkg::*;
#(
	parameter int PACKET_BITS = PacketBitsDef,
	parameter int LANES       = LanesDef
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  emit_req_t                         req,
	input  logic [LANES-1:0][PACKET_BITS-1:0] words,
	output logic                              take_ok,
	efr_out_if.source                         out
);

	localparam int LaneW = $clog2(LANES);

	typedef enum logic [1:0] {
		M_IDLE = 2'b01,
		M_EMIT = 2'b10
	} mstate_t;

	mstate_t          mst_q;
	logic [LaneW-1:0] idx_q;
	logic [LaneW-1:0] skip_q;
	logic             skip_en_q;
	logic             valid_q;

	logic             free;
	logic [LaneW-1:0] req_skip;
	logic [LaneW-1:0] first_idx;
	logic [LaneW-1:0] next_idx;
	logic [LaneW-1:0] inc_idx;
	logic             is_last;
	logic [PACKET_BITS-1:0] cur;

	assign free     = !valid_q || out.ready;
	assign take_ok  = (mst_q == M_IDLE) && free;
	assign req_skip = req.skip_lane[LaneW-1:0];

	always_comb begin
		first_idx = (req.skip_en && (req_skip == '0)) ? LaneW'(1) : '0;
		inc_idx   = idx_q + LaneW'(1);
		next_idx  = (skip_en_q && (inc_idx == skip_q)) ? inc_idx + LaneW'(1) : inc_idx;
		is_last   = (idx_q == LaneW'(LANES - 1)) ||
			(skip_en_q && (skip_q == LaneW'(LANES - 1)) && (idx_q == LaneW'(LANES - 2)));
		cur       = words[idx_q];
	end

	assign out.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mst_q     <= M_IDLE;
			valid_q   <= 1'b0;
			idx_q     <= '0;
			skip_q    <= '0;
			skip_en_q <= 1'b0;
		end else begin
			case (mst_q)
				M_IDLE: begin
					if (req.start_rsp) begin
						valid_q <= 1'b1;
					end else if (out.ready) begin
						valid_q <= 1'b0;
					end
					if (req.frame_done) begin
						mst_q     <= M_EMIT;
						idx_q     <= first_idx;
						skip_q    <= req_skip;
						skip_en_q <= req.skip_en;
					end
				end
				M_EMIT: begin
					if (free) begin
						valid_q <= 1'b1;
						idx_q   <= next_idx;
						if (is_last) begin
							mst_q <= M_IDLE;
						end
					end
				end
				default: begin
					mst_q <= M_IDLE;
					if (out.ready) begin
						valid_q <= 1'b0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((mst_q == M_IDLE) && req.start_rsp) begin
			out.kind             <= req.busy ? KIND_START_BUSY : KIND_START_OK;
			out.lane             <= '0;
			out.chan_num         <= '0;
			out.conversion_data  <= '0;
			out.over_under_range <= 1'b0;
			out.last             <= 1'b1;
		end else if ((mst_q == M_EMIT) && free) begin
			out.kind             <= KIND_WORD;
			out.lane             <= idx_q;
			out.chan_num         <= cur[IdBits-1:0];
			out.conversion_data  <= cur[PACKET_BITS-1:DataLsb];
			out.over_under_range <= cur[FlagPos];
			out.last             <= is_last;
		end
	end

endmodule

### rtl/core/eight_lane_serial_adc_frame_reader.sv
// ----------------------------------------------------------------------------
// eight_lane_serial_adc_frame_reader
// Eight serial data lanes sampled in parallel, MSB first; after a full packet
// one channel word per lane is issued, the status lane skipped after the first.
//
//   channel   dir   payload                                     handshake
//   samples   in    command, sdo_bits                           valid/ready
//   words     out   kind, lane, chan_num, conversion_data,      valid/ready
//                   over_under_range, last
//
// A sample request is taken per cycle while no words are being issued
// and the output register is free.
// A finished packet issues 7 or 8 words from the lanes, one per cycle while
// words are taken; samples stall for that walk. Output is registered: a request
// may enter as the previous result is taken. Reset clears control only.
// ----------------------------------------------------------------------------
module eight_lane_serial_adc_frame_reader
	import efr_pkg::*;
#(
	parameter int PACKET_BITS = PacketBitsDef,
	parameter int LANES       = LanesDef
) (
	input  logic      clk,
	input  logic      arst_n,
	efr_in_if.sink    samples,
	efr_out_if.source words
);

	lane_ctl_t                         lane_ctl;
	emit_req_t                         req;
	logic [LANES-1:0][PACKET_BITS-1:0] lane_words;
	logic                              take_ok;
	logic                              accept;

	assign samples.ready = take_ok;
	assign accept        = samples.valid && take_ok;

	efr_ctrl #(
		.PACKET_BITS(PACKET_BITS),
		.LANES      (LANES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.command (samples.command),
		.lane_ctl(lane_ctl),
		.req     (req)
	);

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		efr_lane #(
			.PACKET_BITS(PACKET_BITS)
		) u_lane (
			.clk (clk),
			.ctl (lane_ctl),
			.sdo (samples.sdo_bits[i]),
			.word(lane_words[i])
		);
	end

	efr_merge #(
		.PACKET_BITS(PACKET_BITS),
		.LANES      (LANES)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.words  (lane_words),
		.take_ok(take_ok),
		.out    (words)
	);

endmodule

### bench/eight_lane_serial_adc_frame_reader_tb.sv
// ----------------------------------------------------------------------------
// eight_lane_serial_adc_frame_reader_tb
// Drives start and clock requests with random gaps while the word channel
// stalls at random. A lane word tracker mirrors the frame reader: it shifts
// the lanes, rotates the status lane and queues the expected words, which
// are compared field by field as they arrive. Covers idle clocks, starts
// while busy, field extremes and many frames of random lane data.
// ----------------------------------------------------------------------------
module eight_lane_serial_adc_frame_reader_tb
	import efr_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StallLimit = 1000;
	localparam int ItemTarget = 470;

	class lane_word_tracker;
		typedef struct {
			kind_t       kind;
			logic [2:0]  lane;
			logic [2:0]  chan_num;
			logic [19:0] conversion_data;
			logic        over_under_range;
			logic        last;
		} lane_word_t;

		bit                      busy;
		bit [4:0]                bits_taken;
		bit [PacketBitsDef-1:0]  lane_bits[LanesDef];
		bit [2:0]                status_ln;
		bit                      no_status_yet = 1'b1;
		lane_word_t              pending_words[$];
		int                      errors;

		function void shift_bits(logic [7:0] sdo);
			if (bits_taken < PacketBitsDef) begin
				foreach (lane_bits[i])
					if (sdo[i])
						lane_bits[i][PacketBitsDef - 1 - bits_taken] = 1'b1;
			end
			bits_taken++;
		endfunction

		function void take_request(logic cmd, logic [7:0] sdo);
			lane_word_t w;
			int remaining;
			w = '{KIND_START_OK, 3'd0, 3'd0, 20'd0, 1'b0, 1'b1};
			if (cmd == CMD_START) begin
				if (busy) begin
					w.kind = KIND_START_BUSY;
					pending_words.push_back(w);
					return;
				end
				busy = 1'b1;
				bits_taken = '0;
				foreach (lane_bits[i])
					lane_bits[i] = '0;
				shift_bits(sdo);
				pending_words.push_back(w);
				return;
			end
			if (!busy)
				return;
			shift_bits(sdo);
			if (bits_taken < PacketBitsDef)
				return;
			busy = 1'b0;
			remaining = no_status_yet ? LanesDef : LanesDef - 1;
			for (int i = 0; i < LanesDef; i++) begin
				if (i == status_ln && !no_status_yet)
					continue;
				remaining--;
				w.kind = KIND_WORD;
				w.lane = 3'(i);
				w.chan_num = lane_bits[i][IdBits-1:0];
				w.over_under_range = lane_bits[i][FlagPos];
				w.conversion_data = lane_bits[i][PacketBitsDef-1:DataLsb];
				w.last = (remaining == 0);
				pending_words.push_back(w);
			end
			if (no_status_yet || status_ln == 3'd0) begin
				no_status_yet = 1'b0;
				status_ln = 3'd7;
			end else begin
				status_ln--;
			end
		endfunction

		function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (act_v !== exp_v) begin
				$error("%s: expected %0h, actual %0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_word(logic [1:0] kind, logic [2:0] lane, logic [2:0] chan_num,
				logic [19:0] conversion_data, logic over_under_range, logic last);
			lane_word_t w;
			if (pending_words.size() == 0) begin
				$error("unexpected result: kind %0h lane %0h", kind, lane);
				errors++;
				return;
			end
			w = pending_words.pop_front();
			compare_field("kind", 32'(w.kind), 32'(kind));
			compare_field("lane", 32'(w.lane), 32'(lane));
			compare_field("chan_num", 32'(w.chan_num), 32'(chan_num));
			compare_field("conversion_data", 32'(w.conversion_data), 32'(conversion_data));
			compare_field("over_under_range", 32'(w.over_under_range), 32'(over_under_range));
			compare_field("last", 32'(w.last), 32'(last));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   quiet;
	int   stalled_cycles;

	lane_word_tracker tracker = new();

	efr_in_if  samples_if ();
	efr_out_if words_if ();

	eight_lane_serial_adc_frame_reader dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_if),
		.words  (words_if)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_request(logic cmd, logic [7:0] sdo);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.command <= cmd;
		samples_if.sdo_bits <= sdo;
		do
			@(posedge clk);
		while (!(samples_if.valid === 1'b1 && samples_if.ready === 1'b1));
		@(negedge clk);
	endtask

	initial begin
		int gap;
		words_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 3);
			if (gap != 0) begin
				words_if.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			words_if.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(words_if.valid === 1'b1 && words_if.ready === 1'b1));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (words_if.valid === 1'b1 && words_if.ready === 1'b1)
				tracker.check_word(words_if.kind, words_if.lane, words_if.chan_num,
					words_if.conversion_data, words_if.over_under_range, words_if.last);
			if (samples_if.valid === 1'b1 && samples_if.ready === 1'b1)
				tracker.take_request(samples_if.command, samples_if.sdo_bits);
			if ((words_if.valid === 1'b1 && words_if.ready === 1'b1) ||
					(samples_if.valid === 1'b1 && samples_if.ready === 1'b1))
				stalled_cycles = 0;
			else
				stalled_cycles++;
			if (stalled_cycles >= StallLimit) begin
				$display("eight_lane_serial_adc_frame_reader regression: fail");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		int bit_mode;
		logic [7:0] sdo;
		arst_n = 1'b0;
		samples_if.valid = 1'b0;
		samples_if.command = CMD_CLOCK;
		samples_if.sdo_bits = '0;
		stalled_cycles = 0;
		quiet = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// clock while idle is dropped
		send_request(CMD_CLOCK, 8'hFF);
		// lane 0 all ones, lane 1 all zeros, lane 3 data only, lane 4 flag and id only
		for (int p = 0; p < PacketBitsDef; p++) begin
			sdo = {3'($urandom), 1'(p >= 20), 1'(p < 20), p[0], 1'b0, 1'b1};
			send_request(p == 0 ? CMD_START : CMD_CLOCK, sdo);
			if (p == 0 || p == PacketBitsDef - 2)
				send_request(CMD_START, 8'h00);
		end
		sent = PacketBitsDef + 2;

		while (sent < ItemTarget) begin
			quiet = ($urandom_range(0, 3) == 0);
			bit_mode = $urandom_range(0, 7);
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3)) send_request(CMD_CLOCK, 8'($urandom));
			for (int p = 0; p < PacketBitsDef; p++) begin
				sdo = (bit_mode == 0) ? 8'hFF : (bit_mode == 1) ? 8'h00 : 8'($urandom);
				send_request(p == 0 ? CMD_START : CMD_CLOCK, sdo);
				sent++;
				if (p != PacketBitsDef - 1 && $urandom_range(0, 15) == 0) begin
					send_request(CMD_START, 8'($urandom));
					sent++;
				end
			end
		end
		samples_if.valid <= 1'b0;

		while (tracker.pending_words.size() != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);
		if (tracker.errors == 0)
			$display("eight_lane_serial_adc_frame_reader regression: pass");
		else
			$display("eight_lane_serial_adc_frame_reader regression: fail");
		$finish;
	end

endmodule

### sim.f
rtl/core/efr_pkg.sv
rtl/core/efr_if.sv
rtl/core/efr_lane.sv
rtl/core/efr_ctrl.sv
rtl/core/efr_merge.sv
rtl/core/eight_lane_serial_adc_frame_reader.sv
bench/eight_lane_serial_adc_frame_reader_tb.sv
